// ===== src/matrix_adjugate_assert.svh =====
// Assertion macros for the matrix adjugate block
`ifndef MATRIX_ADJUGATE_ASSERT_SVH
`define MATRIX_ADJUGATE_ASSERT_SVH
`ifndef SYNTHESIS
`define MADJ_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MADJ_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define MADJ_ASSERT_IMPL(label, clk, rst_n, prop)
`define MADJ_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/madj_pkg.sv =====
// Package: types and constants for the matrix adjugate block
package madj_pkg;
    localparam int MAX_ORDER    = 4;
    localparam int ELEMENT_BITS = 16;
    localparam int CELLS        = MAX_ORDER * MAX_ORDER;
    localparam int IDX_BITS     = $clog2(CELLS);
    localparam int ORD_BITS     = 3;
    localparam logic [ORD_BITS-1:0] ORDER_RESET = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    // one multiply-accumulate request to the shared unit
    typedef struct packed {
        logic clear;
        logic load;
        logic negate;
    } mac_ctl_t;
endpackage

// ===== src/madj_mac.sv =====
// Shared multiply-accumulate unit: product registered, then added or subtracted
module madj_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  madj_pkg::mac_ctl_t                   ctl,
    input  logic signed [madj_pkg::ELEMENT_BITS-1:0] elem,
    input  logic signed [31:0]                   factor,
    output logic signed [31:0]                   prod,
    output logic signed [63:0]                   acc
);
    import madj_pkg::*;

    logic signed [47:0] mul_full;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;

    // multiply stage (16 x 32 bits)
    assign mul_full = elem * factor;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_full);
    end

    // partial products of at most two elements fit in 32 bits
    assign prod = prod_reg[31:0];

    // accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = 64'sd0;
        else if (ctl.load)
            acc_next = ctl.negate ? acc_reg - prod_reg : acc_reg + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= 64'sd0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;
endmodule

// ===== src/matrix_adjugate.sv =====
// Top level: matrix adjugate by cofactor expansion on one shared MAC
//
//  channel   signals                          direction
//  config    matrix_order_we, matrix_order    in
//  element   start, element_value; busy       in; busy out
//  result    result_valid, adjugate_value,    out
//            last_element
//
// Elements load one per cycle; busy stays low while loading.
// After the last element each cofactor is summed over the permutations of its
// minor on one multiplier: each factor passes through FETCH and MUL, each
// product is added in ACC and each result is emitted in EMIT. busy is high until
// the last result has gone.
// Reset clears the order to 3 and the load count. Results cannot be stalled.
module matrix_adjugate (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     matrix_order_we,
    input  logic [madj_pkg::ORD_BITS-1:0]            matrix_order,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [madj_pkg::ELEMENT_BITS-1:0] element_value,
    output logic                                     result_valid,
    output logic signed [63:0]                       adjugate_value,
    output logic                                     last_element
);
    import madj_pkg::*;
`include "matrix_adjugate_assert.svh"

    // Sequencer: for output (i,j) remove row j, col i; the minor has order m=n-1.
    // Its determinant is the signed sum over the permutations of the minor
    // (at most 3! = 6 terms of 3 factors); each product is built by chained
    // passes through the shared unit.

    logic [ORD_BITS-1:0] order_reg;
    logic [4:0]          count_reg;
    logic signed [ELEMENT_BITS-1:0] mem [CELLS];
    state_t              state_reg, state_next;

    logic [2:0] n;
    logic [4:0] total;
    always_comb
    begin
        if (order_reg == 3'd0)
            n = 3'd1;
        else if (order_reg > 3'(MAX_ORDER))
            n = 3'(MAX_ORDER);
        else
            n = order_reg;
        total = 5'(n) * 5'(n);
    end

    logic accept;
    assign accept = start && !busy;

    // load counter and order register
    logic [4:0] wr_idx;
    assign wr_idx = (count_reg >= total) ? 5'd0 : count_reg;
    logic last_load;
    assign last_load = accept && (wr_idx + 5'd1 == total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            count_reg <= 5'd0;
        end
        else if (matrix_order_we)
        begin
            order_reg <= matrix_order;
            count_reg <= 5'd0;
        end
        else if (accept)
            count_reg <= last_load ? 5'd0 : wr_idx + 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            mem[wr_idx[IDX_BITS-1:0]] <= element_value;
    end

    // iteration counters
    logic [3:0] out_reg, out_next;     // output index i*n+j
    logic [2:0] perm_reg, perm_next;   // permutation of minor
    logic [1:0] fac_reg, fac_next;     // factor within product
    logic signed [31:0] prod_reg, prod_next; // running product
    logic signed [ELEMENT_BITS-1:0] rd_reg;
    mac_ctl_t ctl;
    logic signed [63:0] acc;
    logic signed [31:0] mac_prod;

    logic [1:0] oi, oj;
    assign oi = (n == 3'd4) ? out_reg[3:2]
              : (n == 3'd3) ? ((out_reg >= 4'd6) ? 2'd2 : (out_reg >= 4'd3) ? 2'd1 : 2'd0)
              : (n == 3'd2) ? 2'(out_reg[1]) : 2'd0;
    assign oj = 2'(out_reg - 4'(oi) * 4'(n));
    logic [1:0] m;
    assign m = 2'(n - 3'd1);

    // permutation table of 3 elements: column chosen for minor row fac
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] r);
        logic [5:0] e;
        begin
            case (p)
                3'd0: e = {2'd2, 2'd1, 2'd0};
                3'd1: e = {2'd1, 2'd2, 2'd0};
                3'd2: e = {2'd2, 2'd0, 2'd1};
                3'd3: e = {2'd0, 2'd2, 2'd1};
                3'd4: e = {2'd1, 2'd0, 2'd2};
                default: e = {2'd0, 2'd1, 2'd2};
            endcase
            perm_col = e[2*r +: 2];
        end
    endfunction

    // permutation parity and count for order m
    function automatic logic perm_odd(input logic [2:0] p, input logic [1:0] mm);
        begin
            if (mm == 2'd2)
                perm_odd = p[0];
            else
                perm_odd = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
        end
    endfunction
    logic [2:0] nperm;
    assign nperm = (m == 2'd3) ? 3'd6 : (m == 2'd2) ? 3'd2 : 3'd1;

    // minor row r (skip row oj of matrix), minor col c (skip col oi)
    logic [1:0] mr, mc, sr, sc;
    assign mr = fac_reg;
    assign mc = (m == 2'd2) ? ((perm_reg[0] ^ fac_reg[0]) ? 2'd1 : 2'd0)
              : perm_col(perm_reg, fac_reg);
    assign sr = (mr >= oj) ? mr + 2'd1 : mr;
    assign sc = (mc >= oi) ? mc + 2'd1 : mc;
    logic [3:0] raddr;
    assign raddr = 4'(4'(sr) * 4'(n) + 4'(sc));

    logic sign_neg;
    assign sign_neg = perm_odd(perm_reg, m) ^ oi[0] ^ oj[0];

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[raddr];
    end

    madj_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .elem   (rd_reg),
        .factor (prod_reg),
        .prod   (mac_prod),
        .acc    (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_reg   <= 4'd0;
            perm_reg  <= 3'd0;
            fac_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            out_reg   <= out_next;
            perm_reg  <= perm_next;
            fac_reg   <= fac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        out_next   = out_reg;
        perm_next  = perm_reg;
        fac_next   = fac_reg;
        prod_next  = prod_reg;
        ctl        = '0;
        busy       = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                ctl.clear = 1'b1;
                out_next = 4'd0;
                perm_next = 3'd0;
                fac_next = 2'd0;
                prod_next = 32'sd1;
                if (last_load)
                    state_next = (n == 3'd1) ? ST_EMIT : ST_FETCH;
            end
            ST_FETCH:
            begin
                // partial product from the previous factor comes back
                if (fac_reg != 2'd0)
                    prod_next = mac_prod;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // shared unit multiplies rd by the running product
                if (fac_reg == m - 2'd1)
                    state_next = ST_ACC;
                else
                begin
                    fac_next = fac_reg + 2'd1;
                    state_next = ST_FETCH;
                end
            end
            ST_ACC:
            begin
                // MAC product register now holds rd * prod
                ctl.load = 1'b1;
                ctl.negate = sign_neg;
                prod_next = 32'sd1;
                fac_next = 2'd0;
                if (perm_reg + 3'd1 == nperm)
                    state_next = ST_EMIT;
                else
                begin
                    perm_next = perm_reg + 3'd1;
                    state_next = ST_FETCH;
                end
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                ctl.clear = 1'b1;
                perm_next = 3'd0;
                fac_next = 2'd0;
                prod_next = 32'sd1;
                if (5'(out_reg) + 5'd1 == total)
                    state_next = ST_IDLE;
                else
                begin
                    out_next = out_reg + 4'd1;
                    state_next = ST_FETCH;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign adjugate_value = (n == 3'd1) ? 64'sd1 : acc;
    assign last_element = result_valid && (5'(out_reg) + 5'd1 == total);

    `MADJ_ASSERT_IMPL(a_last_ends, clk, rst_n, last_element |=> !busy)
    `MADJ_ASSERT_NEVER(a_res_idle, clk, rst_n, result_valid && !busy)
    `MADJ_ASSERT_IMPL(a_emit_once, clk, rst_n, (result_valid && !last_element) |=> !result_valid)
endmodule
